@@ rtl/phase_flash_residual_assembler_assert.svh @@
// Assertion helper macros for the phase flash residual assembler.
`ifndef PHASE_FLASH_RESIDUAL_ASSEMBLER_ASSERT_SVH
`define PHASE_FLASH_RESIDUAL_ASSEMBLER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PFRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define PFRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/pfra_pkg.sv @@
package pfra_pkg;

    localparam int MAX_PHASES     = 2;
    localparam int MAX_COMPONENTS = 4;
    localparam int FRAC_BITS      = 16;
    localparam int PH_W           = 1;
    localparam int CO_W           = 2;
    localparam int PC_W           = PH_W + CO_W;
    localparam int PC_DEPTH       = MAX_PHASES * MAX_COMPONENTS;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef enum logic [2:0] {
        CMD_POINT   = 3'd0,
        CMD_PHASE   = 3'd1,
        CMD_PAIR    = 3'd2,
        CMD_OVERALL = 3'd3,
        CMD_EVAL    = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_NUM_PHASES = 3'd0,
        CFG_NUM_COMP   = 3'd1,
        CFG_REF_PHASE  = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_USE_OVERALL = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        K_ACTIVE    = 5'd0,
        K_PMASS     = 5'd1,
        K_SAT       = 5'd2,
        K_MSUM      = 5'd3,
        K_MRES      = 5'd4,
        K_PRES      = 5'd5,
        K_CDENS     = 5'd6,
        K_CSTOR     = 5'd7,
        K_CHEM      = 5'd8,
        K_ZFRAC     = 5'd9,
        K_ZRES      = 5'd10,
        K_TCDENS    = 5'd11,
        K_TCSTOR    = 5'd12,
        K_VRES      = 5'd13,
        K_TMASS     = 5'd14,
        K_TSTOR     = 5'd15,
        K_ZSUM      = 5'd16
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE, S_P_RD, S_P_WT, S_P_ACC,
        S_V_RD, S_V_WT, S_V_EMIT,
        S_D_START, S_D_WAIT,
        S_M_RD, S_M_WT, S_M_EMIT,
        S_C_RD, S_C_WT, S_C_EMIT,
        S_K_START, S_K_EMIT,
        S_S_EMIT,
        S_EMIT_WAIT
    } state_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return Q_MAX;
        if (v < -33'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33(33'(a) + 33'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33(33'(a) - 33'(b));
    endfunction

    // floor shift of a 64-bit product, saturated
    function automatic logic signed [31:0] qshift(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        if (s > 64'sd2147483647) return Q_MAX;
        if (s < -64'sd2147483648) return Q_MIN;
        return s[31:0];
    endfunction

endpackage

@@ rtl/pfra_ram.sv @@
module pfra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/pfra_mul.sv @@
// Q16.16 multiply: product register, then a registered shift and saturate.
module pfra_mul import pfra_pkg::*; (
    input  logic               aclk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] q
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(a) * 64'(b);
        q        <= qshift(prod_reg);
    end

endmodule

@@ rtl/pfra_div.sv @@
// Restoring divider for (a << FRAC_BITS) / b, truncated toward zero, saturated.
// One quotient bit a cycle; b != 0 is the caller's job.
module pfra_div import pfra_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [31:0] q
);

    localparam int NW = 32 + FRAC_BITS;

    logic [NW-1:0]     num_reg, num_next;
    logic [32:0]       rem_reg, rem_next;
    logic [31:0]       den_reg, den_next;
    logic [NW-1:0]     quo_reg, quo_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [32:0]       trial;
    logic [32:0]       shifted;
    logic [NW:0]       mag;
    logic signed [NW+1:0] sq;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], num_reg[NW-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start) begin
            num_next  = (a[31] ? NW'(-(NW'(signed'(a)))) : NW'(a)) << FRAC_BITS;
            den_next  = b[31] ? 32'(-b) : 32'(b);
            neg_next  = a[31] ^ b[31];
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb begin
        mag = {1'b0, quo_reg};
        sq  = neg_reg ? -(signed'({1'b0, mag})) : signed'({1'b0, mag});
        if (sq > (NW+2)'(64'sd2147483647)) q = Q_MAX;
        else if (sq < -(NW+2)'(64'sd2147483648)) q = Q_MIN;
        else q = sq[31:0];
    end

    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

endmodule

@@ rtl/phase_flash_residual_assembler.sv @@
// Load words (commands 0 to 3) are written straight into the stores and are
// taken one per cycle while idle. An evaluate word walks the phase and pair
// memories (registered reads) and a shared multiplier and bit-serial divider,
// then emits 6*np + 3*np*nc + 4*nc + 4 result words ending with tlast.
// The 48-bit divider is used once per phase and once per component where its
// guard passes. No new word is taken until the run has been fully delivered.
// No clearing pass after reset.
`include "phase_flash_residual_assembler_assert.svh"
module phase_flash_residual_assembler import pfra_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[2:0], phase_index[3], component_index[5:4], value_a[37:6],
    // value_b[69:38], value_c[101:70], zero fill to 104 bits
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_kind[4:0], result_phase[5], result_component[7:6], result_value[39:8]
    output logic [39:0]  m_tdata,
    // last
    output logic         m_tlast
);

    logic [1:0]  np_cfg_reg;
    logic [2:0]  nc_cfg_reg;
    logic        ref_reg;
    logic [30:0] thr_reg;
    logic        use_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            np_cfg_reg <= 2'd1;
            nc_cfg_reg <= 3'd1;
            ref_reg    <= 1'b0;
            thr_reg    <= '0;
            use_z_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_PHASES:  np_cfg_reg <= cfg_wdata[1:0];
                CFG_NUM_COMP:    nc_cfg_reg <= cfg_wdata[2:0];
                CFG_REF_PHASE:   ref_reg    <= cfg_wdata[0];
                CFG_THRESHOLD:   thr_reg    <= cfg_wdata;
                CFG_USE_OVERALL: use_z_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [1:0] np;
    logic [2:0] nc;
    always_comb begin
        np = (np_cfg_reg == 2'd0) ? 2'd1 : (np_cfg_reg > 2'd2 ? 2'd2 : np_cfg_reg);
        nc = (nc_cfg_reg == 3'd0) ? 3'd1 : (nc_cfg_reg > 3'd4 ? 3'd4 : nc_cfg_reg);
    end
    logic signed [31:0] thr;
    assign thr = {1'b0, thr_reg};

    logic [2:0]         in_cmd;
    logic               in_ph;
    logic [1:0]         in_co;
    logic signed [31:0] in_a, in_b, in_c;
    assign in_cmd = s_tdata[2:0];
    assign in_ph  = s_tdata[3];
    assign in_co  = s_tdata[5:4];
    assign in_a   = s_tdata[37:6];
    assign in_b   = s_tdata[69:38];
    assign in_c   = s_tdata[101:70];

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    state_t state_reg, state_next;
    logic [PH_W-1:0] p_reg, p_next;
    logic [CO_W-1:0] k_reg, k_next;
    logic [2:0]      sub_reg, sub_next;

    // memories
    logic               ph_we;
    logic [95:0]        ph_rdata;
    logic [PH_W-1:0]    ph_raddr;
    logic               pc_we;
    logic [63:0]        pc_rdata, pcr_rdata;
    logic [PC_W-1:0]    pc_raddr, pcr_raddr;
    logic               oz_we;
    logic [31:0]        oz_rdata;

    assign ph_we = s_acc && cmd_t'(in_cmd) == CMD_PHASE;
    assign pc_we = s_acc && cmd_t'(in_cmd) == CMD_PAIR;
    assign oz_we = s_acc && cmd_t'(in_cmd) == CMD_OVERALL;

    pfra_ram #(.WIDTH(96), .DEPTH(MAX_PHASES)) u_ph (
        .aclk(aclk), .we(ph_we), .waddr(in_ph), .wdata({in_c, in_b, in_a}),
        .raddr(ph_raddr), .rdata(ph_rdata));
    pfra_ram #(.WIDTH(64), .DEPTH(PC_DEPTH)) u_pc (
        .aclk(aclk), .we(pc_we), .waddr({in_ph, in_co}), .wdata({in_b, in_a}),
        .raddr(pc_raddr), .rdata(pc_rdata));
    pfra_ram #(.WIDTH(64), .DEPTH(PC_DEPTH)) u_pcr (
        .aclk(aclk), .we(pc_we), .waddr({in_ph, in_co}), .wdata({in_b, in_a}),
        .raddr(pcr_raddr), .rdata(pcr_rdata));
    pfra_ram #(.WIDTH(32), .DEPTH(MAX_COMPONENTS)) u_oz (
        .aclk(aclk), .we(oz_we), .waddr(in_co), .wdata(in_a),
        .raddr(k_reg), .rdata(oz_rdata));

    logic signed [31:0] jac_reg, tft_reg;
    always_ff @(posedge aclk) begin
        if (s_acc && cmd_t'(in_cmd) == CMD_POINT) begin
            jac_reg <= in_a;
            tft_reg <= in_b;
        end
    end

    // per-phase, per-component and total working values
    logic [MAX_PHASES-1:0] act_reg, act_next;
    logic signed [31:0] apv_reg [MAX_PHASES], apv_next [MAX_PHASES];
    logic signed [31:0] pcm_reg [MAX_PHASES], pcm_next [MAX_PHASES];
    logic signed [31:0] pres_reg [MAX_PHASES], pres_next [MAX_PHASES];
    logic signed [31:0] tcm_reg [MAX_COMPONENTS], tcm_next [MAX_COMPONENTS];
    logic signed [31:0] vsum_reg, vsum_next, tmass_reg, tmass_next;
    logic signed [31:0] zsum_reg, zsum_next, msum_reg, msum_next;
    logic signed [31:0] t0_reg, t0_next, t1_reg, t1_next;
    logic signed [31:0] frac_reg, frac_next;

    // shared arithmetic
    logic signed [31:0] mul_a, mul_b, mul_q;
    pfra_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .q(mul_q));

    logic               div_start, div_done;
    logic signed [31:0] div_a, div_b, div_q;
    pfra_div u_div (.aclk(aclk), .aresetn(aresetn), .start(div_start), .a(div_a),
                    .b(div_b), .done(div_done), .q(div_q));

    // output register
    logic        ov_reg, ov_next;
    logic [39:0] od_reg, od_next;
    logic        ol_reg, ol_next;
    logic        emit;
    kind_t       e_kind;
    logic        e_ph;
    logic [1:0]  e_co;
    logic signed [31:0] e_val;
    logic        e_last;

    logic ref_act;
    assign ref_act = (2'(ref_reg) < np) && act_reg[ref_reg];

    logic [PH_W-1:0] pmax;
    logic [CO_W-1:0] kmax;
    assign pmax = PH_W'(np - 2'd1);
    assign kmax = CO_W'(nc - 3'd1);

    logic signed [31:0] vf, dn, pr, mf, mu, mu_ref;
    assign vf     = ph_rdata[31:0];
    assign dn     = ph_rdata[63:32];
    assign pr     = ph_rdata[95:64];
    assign mf     = pc_rdata[31:0];
    assign mu     = pc_rdata[63:32];
    assign mu_ref = pcr_rdata[63:32];

    assign s_tready = (state_reg == S_IDLE);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        p_next = p_reg; k_next = k_reg; sub_next = sub_reg;
        act_next = act_reg; vsum_next = vsum_reg; tmass_next = tmass_reg;
        zsum_next = zsum_reg; msum_next = msum_reg; t0_next = t0_reg; t1_next = t1_reg;
        frac_next = frac_reg;
        for (int i = 0; i < MAX_PHASES; i++) begin
            apv_next[i] = apv_reg[i]; pcm_next[i] = pcm_reg[i]; pres_next[i] = pres_reg[i];
        end
        for (int i = 0; i < MAX_COMPONENTS; i++) tcm_next[i] = tcm_reg[i];
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && cmd_t'(in_cmd) == CMD_EVAL) begin
                    p_next = '0; k_next = '0; sub_next = '0;
                    vsum_next = '0; tmass_next = '0; zsum_next = '0;
                    for (int i = 0; i < MAX_COMPONENTS; i++) tcm_next[i] = '0;
                    state_next = S_P_RD;
                end
            end
            // pass 1: activity, volume sum, phase mass
            S_P_RD: begin
                sub_next = '0;
                state_next = S_P_WT;
            end
            S_P_WT: begin
                act_next[p_reg] = vf > thr;
                apv_next[p_reg] = (vf > thr) ? vf : '0;
                vsum_next = qadd(vsum_reg, (vf > thr) ? vf : 32'sd0);
                state_next = S_P_ACC;
            end
            S_P_ACC: begin
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd2) begin
                    pcm_next[p_reg] = mul_q;
                    tmass_next = qadd(tmass_reg, mul_q);
                    if (p_reg == pmax) begin
                        p_next = '0;
                        state_next = S_V_RD;
                    end else begin
                        p_next = p_reg + 1'b1;
                        state_next = S_P_RD;
                    end
                end
            end
            // pass 2: per-phase results; pressure of ref read first
            S_V_RD: begin
                sub_next = '0;
                state_next = S_V_WT;
            end
            S_V_WT: begin
                // sub 0: ref pressure read; sub 1: own phase; then mass fraction walk
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd0) begin
                    t0_next = pr;
                end else begin
                    pres_next[p_reg] = (act_reg[p_reg] && ref_act) ? qsub(pr, t0_reg) : '0;
                    msum_next = '0;
                    k_next = '0;
                    state_next = S_M_RD;
                end
            end
            S_M_RD: state_next = S_M_WT;
            S_M_WT: begin
                msum_next = qadd(msum_reg, mf);
                if (k_reg == kmax) begin
                    k_next = '0;
                    if (vsum_reg > thr) begin
                        state_next = S_D_START;
                    end else begin
                        t1_next = '0;
                        sub_next = '0;
                        state_next = S_V_EMIT;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                    state_next = S_M_RD;
                end
            end
            S_D_START: state_next = S_D_WAIT;
            S_D_WAIT: begin
                if (div_done) begin
                    t1_next = div_q;
                    sub_next = '0;
                    state_next = S_V_EMIT;
                end
            end
            S_V_EMIT: begin
                if (!ov_reg || m_tready) begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == 3'd5) begin
                        if (p_reg == pmax) begin
                            p_next = '0; k_next = '0; sub_next = '0;
                            state_next = S_C_RD;
                        end else begin
                            p_next = p_reg + 1'b1;
                            state_next = S_V_RD;
                        end
                    end
                end
            end
            // pass 3: pairs
            S_C_RD: begin
                sub_next = '0;
                state_next = S_C_WT;
            end
            S_C_WT: begin
                // mul pcm*mf: issued in C_WT, ready at sub 2 through the product and output registers; then jac*ccm
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd0) begin
                    t1_next = (act_reg[p_reg] && ref_act) ? qsub(mu, mu_ref) : '0;
                end else if (sub_reg == 3'd2) begin
                    t0_next = mul_q;
                    tcm_next[k_reg] = qadd(tcm_reg[k_reg], mul_q);
                end else if (sub_reg == 3'd4) begin
                    frac_next = mul_q;
                    sub_next = '0;
                    state_next = S_C_EMIT;
                end
            end
            S_C_EMIT: begin
                if (!ov_reg || m_tready) begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == 3'd2) begin
                        if (k_reg == kmax) begin
                            k_next = '0;
                            if (p_reg == pmax) begin
                                p_next = '0;
                                sub_next = '0;
                                state_next = S_K_START;
                            end else begin
                                p_next = p_reg + 1'b1;
                                state_next = S_C_RD;
                            end
                        end else begin
                            k_next = k_reg + 1'b1;
                            state_next = S_C_RD;
                        end
                    end
                end
            end
            // pass 4: per component
            S_K_START: begin
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd7) sub_next = 3'd3;
                if (tmass_reg > thr) begin
                    if (sub_reg == 3'd0) begin
                        state_next = S_K_START;
                    end else if (div_done) begin
                        frac_next = div_q;
                    end
                end else begin
                    frac_next = '0;
                end
                // wait until jac*tcm is ready and, if the divide was started, until it is done
                if (sub_reg >= 3'd3 && (!(tmass_reg > thr) || div_done)) begin
                    t0_next = mul_q;
                    sub_next = '0;
                    state_next = S_K_EMIT;
                end
            end
            S_K_EMIT: begin
                if (!ov_reg || m_tready) begin
                    if (sub_reg == 3'd0) begin
                        zsum_next = qadd(zsum_reg, use_z_reg ? oz_rdata : frac_reg);
                    end
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == 3'd3) begin
                        sub_next = '0;
                        if (k_reg == kmax) begin
                            k_next = '0;
                            state_next = S_S_EMIT;
                        end else begin
                            k_next = k_reg + 1'b1;
                            state_next = S_K_START;
                        end
                    end
                end
            end
            S_S_EMIT: begin
                if (!ov_reg || m_tready) begin
                    sub_next = sub_reg + 3'd1;
                    if (sub_reg == 3'd3) begin
                        sub_next = '0;
                        state_next = S_EMIT_WAIT;
                    end
                end
            end
            S_EMIT_WAIT: begin
                if (!ov_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control and emitted values
    always_comb begin
        ph_raddr  = p_reg;
        pc_raddr  = {p_reg, k_reg};
        pcr_raddr = {ref_reg, k_reg};
        mul_a = jac_reg; mul_b = tmass_reg;
        div_start = 1'b0; div_a = apv_reg[p_reg]; div_b = vsum_reg;
        emit = 1'b0; e_kind = K_ACTIVE; e_ph = 1'b0; e_co = '0; e_val = '0; e_last = 1'b0;
        unique case (state_reg)
            S_P_ACC: begin
                mul_a = apv_reg[p_reg]; mul_b = dn;
            end
            S_V_RD: ph_raddr = ref_reg;
            S_V_WT: ph_raddr = p_reg;
            S_D_START: div_start = 1'b1;
            S_C_WT: begin
                mul_a = (sub_reg == 3'd2) ? jac_reg : pcm_reg[p_reg];
                mul_b = (sub_reg == 3'd2) ? mul_q : mf;
                if (sub_reg >= 3'd3) mul_b = t0_reg;
            end
            S_K_START: begin
                div_a = tcm_reg[k_reg]; div_b = tmass_reg;
                div_start = (sub_reg == 3'd0) && (tmass_reg > thr);
                mul_a = jac_reg; mul_b = tcm_reg[k_reg];
            end
            S_V_EMIT: begin
                emit = 1'b1; e_ph = p_reg;
                case (sub_reg)
                    3'd0: begin e_kind = K_ACTIVE; e_val = act_reg[p_reg] ? Q_ONE : '0; end
                    3'd1: begin e_kind = K_PMASS; e_val = pcm_reg[p_reg]; end
                    3'd2: begin e_kind = K_SAT; e_val = t1_reg; end
                    3'd3: begin e_kind = K_MSUM; e_val = msum_reg; end
                    3'd4: begin
                        e_kind = K_MRES;
                        e_val = act_reg[p_reg] ? qsub(msum_reg, Q_ONE) : '0;
                    end
                    default: begin e_kind = K_PRES; e_val = pres_reg[p_reg]; end
                endcase
            end
            S_C_EMIT: begin
                emit = 1'b1; e_ph = p_reg; e_co = k_reg;
                case (sub_reg)
                    3'd0: begin e_kind = K_CDENS; e_val = t0_reg; end
                    3'd1: begin e_kind = K_CSTOR; e_val = frac_reg; end
                    default: begin e_kind = K_CHEM; e_val = t1_reg; end
                endcase
            end
            S_K_EMIT: begin
                emit = 1'b1; e_co = k_reg;
                case (sub_reg)
                    3'd0: begin e_kind = K_ZFRAC; e_val = frac_reg; end
                    3'd1: begin
                        e_kind = K_ZRES;
                        e_val = use_z_reg ? qsub(frac_reg, oz_rdata) : '0;
                    end
                    3'd2: begin e_kind = K_TCDENS; e_val = tcm_reg[k_reg]; end
                    default: begin e_kind = K_TCSTOR; e_val = t0_reg; end
                endcase
            end
            S_S_EMIT: begin
                emit = 1'b1;
                mul_a = jac_reg; mul_b = tmass_reg;
                case (sub_reg)
                    3'd0: begin e_kind = K_VRES; e_val = qsub(vsum_reg, tft_reg); end
                    3'd1: begin e_kind = K_TMASS; e_val = tmass_reg; end
                    3'd2: begin e_kind = K_TSTOR; e_val = mul_q; end
                    default: begin e_kind = K_ZSUM; e_val = zsum_reg; e_last = 1'b1; end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        ov_next = ov_reg; od_next = od_reg; ol_next = ol_reg;
        if (m_tvalid && m_tready) ov_next = 1'b0;
        if (emit && (!ov_reg || m_tready)) begin
            ov_next = 1'b1;
            od_next = {e_val, e_co, e_ph, e_kind};
            ol_next = e_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        od_reg <= od_next; ol_reg <= ol_next;
        p_reg <= p_next; k_reg <= k_next; sub_reg <= sub_next;
        act_reg <= act_next; vsum_reg <= vsum_next; tmass_reg <= tmass_next;
        zsum_reg <= zsum_next; msum_reg <= msum_next; t0_reg <= t0_next; t1_reg <= t1_next;
        frac_reg <= frac_next;
        apv_reg <= apv_next; pcm_reg <= pcm_next; pres_reg <= pres_next; tcm_reg <= tcm_next;
    end

    `PFRA_ASSERT_IMP(a_busy_no_accept, state_reg != S_IDLE, !s_tready)
    `PFRA_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PFRA_ASSERT_IMP(a_last_is_zsum, m_tvalid && m_tlast, m_tdata[4:0] == K_ZSUM)

endmodule

@@ tb/pfra_residual_checker.sv @@
`timescale 1ns / 100ps
module pfra_residual_checker import pfra_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        kind_t       kind;
        logic        phase;
        logic [1:0]  comp;
        logic [31:0] value;
        logic        last;
    } residual_t;

    residual_t pending_results[$];

    logic [1:0] cfg_np;
    logic [2:0] cfg_nc;
    logic       cfg_ref;
    longint     cfg_thr;
    logic       cfg_useov;

    longint jac, tfrac;
    longint vfrac[2], dens[2], pres[2];
    longint mfrac[8], chem_pot[8];
    longint zfrac[4];

    assign pending = pending_results.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint fx_sub(input longint a, input longint b);
        return clamp32(a - b);
    endfunction

    // floor of the shifted product
    function automatic longint fx_mul(input longint a, input longint b);
        return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint fx_div(input longint a, input longint b);
        if (b == 0) return 0;
        return clamp32((a * 65536) / b);
    endfunction

    task automatic push_result(input kind_t k, input int p, input int c, input longint v,
                               input logic last);
        residual_t r;
        r.kind  = k;
        r.phase = p[0];
        r.comp  = c[1:0];
        r.value = v[31:0];
        r.last  = last;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic assemble_residuals();
        int     np, nc, rp, i;
        logic   act[2];
        logic   ref_act;
        longint apv[2], pcm[2], ccm[8], tcm[4];
        longint vsum, tmass, zsum, msum, pr, ch, fr, rs;
        vsum = 0; tmass = 0; zsum = 0;
        np = (cfg_np == 0) ? 1 : (cfg_np > MAX_PHASES) ? MAX_PHASES : int'(cfg_np);
        nc = (cfg_nc == 0) ? 1 : (cfg_nc > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(cfg_nc);
        rp = int'(cfg_ref);
        for (int k = 0; k < 4; k++) tcm[k] = 0;
        for (int p = 0; p < np; p++) begin
            act[p] = vfrac[p] > cfg_thr;
            apv[p] = act[p] ? vfrac[p] : 0;
            vsum = fx_add(vsum, apv[p]);
            pcm[p] = fx_mul(apv[p], dens[p]);
            tmass = fx_add(tmass, pcm[p]);
        end
        ref_act = (rp < np) && act[rp];
        for (int p = 0; p < np; p++) begin
            msum = 0;
            pr = 0;
            for (int k = 0; k < nc; k++) msum = fx_add(msum, mfrac[p*4+k]);
            if (act[p] && ref_act) pr = fx_sub(pres[p], pres[rp]);
            push_result(K_ACTIVE, p, 0, act[p] ? 65536 : 0, 1'b0);
            push_result(K_PMASS, p, 0, pcm[p], 1'b0);
            push_result(K_SAT, p, 0, (vsum > cfg_thr) ? fx_div(apv[p], vsum) : 0, 1'b0);
            push_result(K_MSUM, p, 0, msum, 1'b0);
            push_result(K_MRES, p, 0, act[p] ? fx_sub(msum, 65536) : 0, 1'b0);
            push_result(K_PRES, p, 0, pr, 1'b0);
        end
        for (int p = 0; p < np; p++) begin
            for (int k = 0; k < nc; k++) begin
                i = p*4 + k;
                ch = 0;
                ccm[i] = fx_mul(pcm[p], mfrac[i]);
                tcm[k] = fx_add(tcm[k], ccm[i]);
                if (act[p] && ref_act) ch = fx_sub(chem_pot[i], chem_pot[rp*4+k]);
                push_result(K_CDENS, p, k, ccm[i], 1'b0);
                push_result(K_CSTOR, p, k, fx_mul(jac, ccm[i]), 1'b0);
                push_result(K_CHEM, p, k, ch, 1'b0);
            end
        end
        for (int k = 0; k < nc; k++) begin
            fr = (tmass > cfg_thr) ? fx_div(tcm[k], tmass) : 0;
            rs = 0;
            if (cfg_useov) begin
                zsum = fx_add(zsum, zfrac[k]);
                rs = fx_sub(fr, zfrac[k]);
            end else begin
                zsum = fx_add(zsum, fr);
            end
            push_result(K_ZFRAC, 0, k, fr, 1'b0);
            push_result(K_ZRES, 0, k, rs, 1'b0);
            push_result(K_TCDENS, 0, k, tcm[k], 1'b0);
            push_result(K_TCSTOR, 0, k, fx_mul(jac, tcm[k]), 1'b0);
        end
        push_result(K_VRES, 0, 0, fx_sub(vsum, tfrac), 1'b0);
        push_result(K_TMASS, 0, 0, tmass, 1'b0);
        push_result(K_TSTOR, 0, 0, fx_mul(jac, tmass), 1'b0);
        push_result(K_ZSUM, 0, 0, zsum, 1'b1);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] residual error: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [2:0] cmd;
        logic       ph;
        logic [1:0] co;
        longint     va, vb, vc;
        residual_t  want;
        if (!aresetn) begin
            cfg_np = 1; cfg_nc = 1; cfg_ref = 0; cfg_thr = 0; cfg_useov = 0;
            fail_count = 0;
            pending_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NUM_PHASES:  cfg_np = cfg_wdata[1:0];
                    CFG_NUM_COMP:    cfg_nc = cfg_wdata[2:0];
                    CFG_REF_PHASE:   cfg_ref = cfg_wdata[0];
                    CFG_THRESHOLD:   cfg_thr = longint'(cfg_wdata);
                    CFG_USE_OVERALL: cfg_useov = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                cmd = s_tdata[2:0];
                ph  = s_tdata[3];
                co  = s_tdata[5:4];
                va  = longint'($signed(s_tdata[37:6]));
                vb  = longint'($signed(s_tdata[69:38]));
                vc  = longint'($signed(s_tdata[101:70]));
                case (cmd)
                    CMD_POINT: begin
                        jac = va; tfrac = vb;
                    end
                    CMD_PHASE: begin
                        vfrac[ph] = va; dens[ph] = vb; pres[ph] = vc;
                    end
                    CMD_PAIR: begin
                        mfrac[{ph, co}] = va; chem_pot[{ph, co}] = vb;
                    end
                    CMD_OVERALL: zfrac[co] = va;
                    CMD_EVAL:    assemble_residuals();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected word", m_tdata[31:0], 32'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[4:0] != want.kind)
                        flag_mismatch("kind", 32'(m_tdata[4:0]), 32'(want.kind));
                    if (m_tdata[5] != want.phase)
                        flag_mismatch("phase", 32'(m_tdata[5]), 32'(want.phase));
                    if (m_tdata[7:6] != want.comp)
                        flag_mismatch("component", 32'(m_tdata[7:6]), 32'(want.comp));
                    if (m_tdata[39:8] != want.value)
                        flag_mismatch("value", m_tdata[39:8], want.value);
                    if (m_tlast != want.last)
                        flag_mismatch("tlast", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

endmodule

@@ tb/phase_flash_residual_assembler_tb.sv @@
`timescale 1ns / 100ps
module phase_flash_residual_assembler_tb import pfra_pkg::*;;

    localparam int CYCLE_LIMIT = 2000000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending;
    int           cycle_count;
    int           sent_items;
    logic         src_no_gaps;

    phase_flash_residual_assembler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    pfra_residual_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk) cycle_count++;
        $display("phase_flash_residual_assembler: mismatch");
        $finish;
    end

    // result sink: random stall per word, with stall-free stretches
    initial begin
        int stall;
        int words;
        logic no_stall;
        m_tready = 1'b0;
        words = 0;
        no_stall = 1'b0;
        forever begin
            if (words % 50 == 0) no_stall = ($urandom_range(0, 2) == 0);
            stall = no_stall ? 0 : $urandom_range(0, 8);
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            words++;
        end
    end

    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 65536);
            2: return 32'($urandom_range(0, 131072)) - 32'd65536;
            3: case ($urandom_range(0, 3))
                   0: return 32'h7fffffff;
                   1: return 32'h80000000;
                   2: return 32'h0;
                   default: return 32'h00010000;
               endcase
            4: return $urandom_range(0, 4096);
            5: return $urandom_range(0, 100 * 65536);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [30:0] data);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // called at a falling edge; a gap of zero puts the word right behind the last one
    task automatic send_word(input logic [2:0] cmd, input logic ph, input logic [1:0] co,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 8);
        repeat (gap) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {2'b00, c, b, a, co, ph, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        sent_items++;
    endtask

    task automatic load_everything();
        send_word(CMD_POINT, 1'b0, 2'd0, pick_q(), pick_q(), pick_q());
        for (int p = 0; p < 2; p++)
            send_word(CMD_PHASE, p[0], 2'd0, pick_q(), pick_q(), pick_q());
        for (int i = 0; i < 8; i++)
            send_word(CMD_PAIR, i[2], i[1:0], pick_q(), pick_q(), pick_q());
        for (int k = 0; k < 4; k++)
            send_word(CMD_OVERALL, 1'b0, k[1:0], pick_q(), pick_q(), pick_q());
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic eval_with(input logic [1:0] np, input logic [2:0] nc, input logic rp,
                             input logic [30:0] thr, input logic useov);
        wait_idle();
        write_reg(CFG_NUM_PHASES, 31'(np));
        write_reg(CFG_NUM_COMP, 31'(nc));
        write_reg(CFG_REF_PHASE, 31'(rp));
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_USE_OVERALL, 31'(useov));
        send_word(CMD_EVAL, 1'b0, 2'd0, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [30:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return 31'h7fffffff;
            2: return 31'($urandom_range(0, 65536));
            3: return 31'($urandom_range(0, 4096));
            default: return 31'($urandom);
        endcase
    endfunction

    initial begin
        logic [2:0] cmd;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_NUM_PHASES;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent_items = 0;
        src_no_gaps = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every store written once, then the corner settings
        load_everything();
        eval_with(2'd2, 3'd4, 1'b0, 31'd0, 1'b1);
        send_word(3'd5, 1'b1, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_word(3'd6, 1'b0, 2'd0, 32'h0, 32'h0, 32'h0);
        send_word(3'd7, 1'b1, 2'd1, $urandom, $urandom, $urandom);
        eval_with(2'd1, 3'd2, 1'b1, 31'd0, 1'b0);          // reference out of use
        eval_with(2'd2, 3'd4, 1'b1, 31'h7fffffff, 1'b1);   // nothing active
        eval_with(2'd0, 3'd0, 1'b0, 31'd65536, 1'b0);      // counts of zero
        eval_with(2'd3, 3'd7, 1'b1, 31'd1, 1'b1);          // counts above max

        while (sent_items < 310) begin
            logic [1:0] np;
            logic [2:0] nc;
            logic       rp, uo;
            logic [30:0] thr;
            np = 2'($urandom_range(0, 3));
            nc = 3'($urandom_range(0, 7));
            rp = 1'($urandom_range(0, 1));
            uo = 1'($urandom_range(0, 1));
            thr = pick_threshold();
            src_no_gaps = ($urandom_range(0, 3) == 0);
            for (int r = $urandom_range(1, 4); r > 0; r--) begin
                for (int j = $urandom_range(1, 6); j > 0; j--) begin
                    cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 3));
                    send_word(cmd, 1'($urandom), 2'($urandom), pick_q(), pick_q(), pick_q());
                end
                if (r == 1 || $urandom_range(0, 1) == 0) begin
                    eval_with(np, nc, rp, thr, uo);
                    if ($urandom_range(0, 1) == 0) begin
                        np = 2'($urandom_range(0, 3));
                        nc = 3'($urandom_range(0, 7));
                    end
                end else begin
                    send_word(CMD_EVAL, 1'b0, 2'd0, $urandom, $urandom, $urandom);
                end
            end
        end

        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("phase_flash_residual_assembler: match");
        end else begin
            $display("phase_flash_residual_assembler: mismatch");
        end
        $finish;
    end

endmodule
